// ----- rtl/atsc_pkg.sv -----
`default_nettype none

package atsc_pkg;

   localparam int SIZE_W    = 16;
   localparam int PROC_W    = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [SIZE_W-1:0] MIN_SIZE        = 16'd512;
   localparam logic [SIZE_W-1:0] RESET_LIMIT     = 16'd8192;
   localparam logic [SIZE_W-1:0] RESET_SIZE      = 16'd8192;
   localparam logic [SIZE_W-1:0] RESET_REDUCE    = 16'd50;
   localparam logic [SIZE_W-1:0] RESET_INCREASE  = 16'd264;

   localparam logic [CSR_IDX_W-1:0] CSR_READ_LIMIT         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_LIMIT        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCE_THRESHOLD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREASE_THRESHOLD = 2'd3;

   typedef struct packed {
      logic [SIZE_W-1:0] read_limit;
      logic [SIZE_W-1:0] write_limit;
      logic [SIZE_W-1:0] reduce_threshold;
      logic [SIZE_W-1:0] increase_threshold;
   } cfg_type;

   typedef struct packed {
      logic              cmd;
      logic [PROC_W-1:0] proc_number;
      logic [SIZE_W-1:0] rtx_current;
      logic [SIZE_W-1:0] srtt_scaled;
   } item_type;

   typedef struct packed {
      logic [SIZE_W-1:0] read_size;
      logic [SIZE_W-1:0] write_size;
   } sizes_type;

endpackage

`default_nettype wire

// ----- rtl/atsc_if.sv -----
`default_nettype none

interface atsc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic [atsc_pkg::PROC_W-1:0]   proc_number;
   logic [atsc_pkg::SIZE_W-1:0]   rtx_current;
   logic [atsc_pkg::SIZE_W-1:0]   srtt_scaled;

   modport source (output valid, cmd, proc_number, rtx_current, srtt_scaled, input ready);
   modport sink   (input valid, cmd, proc_number, rtx_current, srtt_scaled, output ready);
endinterface

interface atsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [atsc_pkg::SIZE_W-1:0]   read_size;
   logic [atsc_pkg::SIZE_W-1:0]   write_size;
   logic                          adjusted;

   modport source (output valid, read_size, write_size, adjusted, input ready);
   modport sink   (input valid, read_size, write_size, adjusted, output ready);
endinterface

interface atsc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [atsc_pkg::CSR_IDX_W-1:0] index;
   logic [atsc_pkg::SIZE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/adaptive_transfer_size_control.sv -----
// A transaction accepted on req is held in the input register; its updated sizes are then
// captured in the output register, which drives rsp.
// Throughput: one transaction per cycle while rsp does not stall; the size registers update once per event.
// Backpressure on rsp stalls the input register and then req.ready.
// Reset (synchronous, active high): sizes and limits go to 8192, reduce threshold 50,
// increase threshold 264; no transaction in flight.
`default_nettype none

module adaptive_transfer_size_control (
   input  wire logic  clock,
   input  wire logic  reset,
   atsc_req_if.sink   req,
   atsc_rsp_if.source rsp,
   atsc_csr_if.sink   csr
);
   import atsc_pkg::*;

   cfg_type   cfg;
   item_type  req_item;
   item_type  s1_item_ff;
   logic      s1_valid_ff;
   logic      s1_valid_in;
   sizes_type cur_ff;
   sizes_type cur_in;
   logic      adjusted_in;
   sizes_type out_sizes_ff;
   logic      out_adjusted_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   logic      advance;
   logic      req_fire;

   assign csr.ready = 1'b1;

   atsc_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr.valid),
      .wr_index (csr.index),
      .wr_data  (csr.data),
      .cfg      (cfg)
   );

   atsc_update u_update (
      .item     (s1_item_ff),
      .cfg      (cfg),
      .cur      (cur_ff),
      .nxt      (cur_in),
      .adjusted (adjusted_in)
   );

   assign req_item.cmd         = req.cmd;
   assign req_item.proc_number = req.proc_number;
   assign req_item.rtx_current = req.rtx_current;
   assign req_item.srtt_scaled = req.srtt_scaled;

   assign advance   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         out_valid_ff      <= 1'b0;
         cur_ff.read_size  <= RESET_SIZE;
         cur_ff.write_size <= RESET_SIZE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            cur_ff <= cur_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         out_sizes_ff    <= cur_in;
         out_adjusted_ff <= adjusted_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.read_size  = out_sizes_ff.read_size;
   assign rsp.write_size = out_sizes_ff.write_size;
   assign rsp.adjusted   = out_adjusted_ff;

endmodule

`default_nettype wire

// ----- rtl/atsc_cfg.sv -----
`default_nettype none

module atsc_cfg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           wr_en,
   input  wire logic [atsc_pkg::CSR_IDX_W-1:0] wr_index,
   input  wire logic [atsc_pkg::SIZE_W-1:0]    wr_data,
   output atsc_pkg::cfg_type                   cfg
);
   import atsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_READ_LIMIT:         cfg_in.read_limit         = wr_data;
            CSR_WRITE_LIMIT:        cfg_in.write_limit        = wr_data;
            CSR_REDUCE_THRESHOLD:   cfg_in.reduce_threshold   = wr_data;
            CSR_INCREASE_THRESHOLD: cfg_in.increase_threshold = wr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_limit         <= RESET_LIMIT;
         cfg_ff.write_limit        <= RESET_LIMIT;
         cfg_ff.reduce_threshold   <= RESET_REDUCE;
         cfg_ff.increase_threshold <= RESET_INCREASE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/atsc_update.sv -----
`default_nettype none

module atsc_update (
   input  atsc_pkg::item_type  item,
   input  atsc_pkg::cfg_type   cfg,
   input  atsc_pkg::sizes_type cur,
   output atsc_pkg::sizes_type nxt,
   output logic                adjusted
);
   import atsc_pkg::*;

   typedef enum logic [1:0] {KIND_NONE, KIND_READ, KIND_WRITE} kind_type;

   function automatic kind_type proc_kind(input logic [PROC_W-1:0] proc);
      unique case (proc)
         5'd6, 5'd16: proc_kind = KIND_READ;
         5'd8:        proc_kind = KIND_WRITE;
         default:     proc_kind = KIND_NONE;
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] shrink(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] half;
      half = {1'b0, size[SIZE_W-1:1]};
      if (size > MIN_SIZE) begin
         shrink = (half < MIN_SIZE) ? MIN_SIZE : half;
      end else begin
         shrink = size;
      end
   endfunction

   function automatic logic [SIZE_W-1:0] grow(input logic [SIZE_W-1:0] size,
                                              input logic [SIZE_W-1:0] limit);
      logic [SIZE_W:0] sum;
      sum = {1'b0, size} + {1'b0, MIN_SIZE};
      if (size >= limit) begin
         grow = size;
      end else if (sum > {2'b00, limit[SIZE_W-1:1]}) begin
         grow = limit;
      end else begin
         grow = sum[SIZE_W-1:0];
      end
   endfunction

   kind_type kind;
   logic     hold_shrink;
   logic     may_grow;

   always_comb begin
      kind        = proc_kind(item.proc_number);
      hold_shrink = (item.rtx_current != '0) && (item.rtx_current < cfg.reduce_threshold);
      may_grow    = item.srtt_scaled < cfg.increase_threshold;
      nxt         = cur;
      if (!item.cmd) begin
         if (!hold_shrink) begin
            nxt.read_size  = shrink(cur.read_size);
            nxt.write_size = shrink(cur.write_size);
         end
      end else if (may_grow) begin
         unique case (kind)
            KIND_READ:  nxt.read_size  = grow(cur.read_size, cfg.read_limit);
            KIND_WRITE: nxt.write_size = grow(cur.write_size, cfg.write_limit);
            default:    nxt = cur;
         endcase
      end
      adjusted = (nxt != cur);
   end

endmodule

`default_nettype wire

// ----- rtl/atsc_check.sv -----
`default_nettype none

module atsc_check (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [atsc_pkg::SIZE_W-1:0] rsp_read_size,
   input wire logic [atsc_pkg::SIZE_W-1:0] rsp_write_size,
   input wire logic                        rsp_adjusted
);
   import atsc_pkg::*;

   logic              rsp_fire;
   logic [SIZE_W-1:0] last_read_ff;
   logic [SIZE_W-1:0] last_write_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_read_ff  <= RESET_SIZE;
         last_write_ff <= RESET_SIZE;
      end else if (rsp_fire) begin
         last_read_ff  <= rsp_read_size;
         last_write_ff <= rsp_write_size;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_size) && $stable(rsp_write_size)
         && $stable(rsp_adjusted))
      else $error("rsp payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_adjusted: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_adjusted == ((rsp_read_size != last_read_ff)
         || (rsp_write_size != last_write_ff)))
      else $error("adjusted flag disagrees with size change");

endmodule

bind adaptive_transfer_size_control atsc_check u_atsc_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_read_size  (rsp.read_size),
   .rsp_write_size (rsp.write_size),
   .rsp_adjusted   (rsp.adjusted)
);

`default_nettype wire
